// ----- hw/rtl/bsde_pkg.sv -----
package bsde_pkg;

  // default sizes of the block
  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned MAX_DIM_DEF     = 4;
  localparam int unsigned MAX_DEGREE_DEF  = 7;
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned CFG_W     = 7;   // widest configuration register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned Q16_W     = 17;  // u, knots and alpha
  localparam int unsigned CNT_W     = 7;   // span and multiplicity fields
  localparam int unsigned DIV_N_W   = 33;  // dividend of the shared divider

  localparam logic [Q16_W-1:0] ONE_Q16 = 17'd65536;

  // register reset values
  localparam logic [2:0] DEGREE_RST      = 3'd3;
  localparam logic [2:0] DIMENSION_RST   = 3'd2;
  localparam logic [6:0] POINT_COUNT_RST = 7'd4;
  localparam logic       KNOT_MODE_RST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE,
    CFG_DIMENSION,
    CFG_POINT_COUNT,
    CFG_KNOT_MODE
  } cfg_index_e;

  typedef enum logic {
    CMD_WRITE,
    CMD_EVAL
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_DEBOOR,
    STAT_COPY_ONE,
    STAT_COPY_TWO,
    STAT_UNDEF,
    STAT_MULT_HIGH
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_SETUP_WAIT,
    S_SEARCH,
    S_CHECK,
    S_LOAD_RD,
    S_LOAD_WR,
    S_KNOT_I,
    S_KNOT_J,
    S_DIV,
    S_ROW_RDL,
    S_ROW_RDR,
    S_MUL_LO,
    S_MUL_HI,
    S_ROW_WR,
    S_EMIT_RD,
    S_EMIT_LD,
    S_ERR
  } fsm_state_e;

endpackage

// ----- hw/rtl/bsde_ram.sv -----
module bsde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bspline_de_boor_evaluator.sv -----
// B-spline point evaluator (de Boor, uniform opened or clamped knots). A write item stores one
// control-point coordinate; an evaluate item returns the point at u one coordinate per item (last
// marks the final one), or a single status item on an error. All arithmetic runs through one shared
// restoring divider and one 18-bit multiplier under a sequencer, and the block takes no item while
// an evaluation runs. An evaluation starts with a setup divide for the knot step, then generates one
// knot per cycle up to span+degree, loads the triangle (h = degree - multiplicity), then for each of
// the h*(h+1)/2 triangle entries runs a divide (skipped when u is at or below the lower knot or
// the two knots coincide) and a blend per coordinate, then emits each coordinate. The divider
// dominates the evaluation time. Configuration must be stable while an evaluation runs; the stores
// need no clearing after reset.
module bspline_de_boor_evaluator #(
  parameter int unsigned MAX_POINTS  = bsde_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_DIM     = bsde_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_DEGREE  = bsde_pkg::MAX_DEGREE_DEF,
  parameter int unsigned COORD_WIDTH = bsde_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bsde_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bsde_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic [5:0]                           point_index_i,
  input  logic [1:0]                           coord_select_i,
  input  logic signed [COORD_WIDTH-1:0]        coord_in_i,
  input  logic [bsde_pkg::Q16_W-1:0]           param_u_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           coord_number_o,
  output logic signed [COORD_WIDTH-1:0]        coord_out_o,
  output logic [2:0]                           status_o,
  output logic [bsde_pkg::CNT_W-1:0]           knot_span_o,
  output logic [bsde_pkg::CNT_W-1:0]           multiplicity_o,
  output logic                                 last_o
);
  import bsde_pkg::*;

  localparam int unsigned DIMW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned PIW   = $clog2(MAX_POINTS);
  localparam int unsigned RJW   = $clog2(MAX_DEGREE + 1);
  localparam int unsigned JW    = $clog2(MAX_DEGREE + 2);
  localparam int unsigned KIW   = $clog2(MAX_POINTS + 2 * MAX_DEGREE + 2);
  localparam int unsigned SW    = KIW + 2;
  localparam int unsigned WIN   = 2 * MAX_DEGREE;
  localparam int unsigned WXW   = $clog2(WIN);
  localparam int unsigned DW    = $clog2(MAX_POINTS + MAX_DEGREE + 1);
  localparam int unsigned DCW   = $clog2(DIV_N_W + 1);
  localparam int unsigned SAW   = PIW + DIMW;
  localparam int unsigned RAW   = RJW + DIMW;
  localparam int unsigned STORE_DEPTH = MAX_POINTS << DIMW;
  localparam int unsigned ROW_DEPTH   = (MAX_DEGREE + 1) << DIMW;
  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned HW    = CW - 15;
  localparam int unsigned BW    = (HW > 17) ? HW : 17;
  localparam int unsigned PW    = 18 + BW;
  localparam int unsigned VW    = ((PW > CW) ? PW : CW) + 1;
  localparam logic [PW-1:0] HALF_LSB = PW'(32768);

  // configuration registers
  logic [2:0] degree_q, dimension_q;
  logic [6:0] point_count_q;
  logic       knot_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q      <= DEGREE_RST;
      dimension_q   <= DIMENSION_RST;
      point_count_q <= POINT_COUNT_RST;
      knot_mode_q   <= KNOT_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DEGREE:      degree_q      <= cfg_data_i[2:0];
        CFG_DIMENSION:   dimension_q   <= cfg_data_i[2:0];
        CFG_POINT_COUNT: point_count_q <= cfg_data_i[6:0];
        CFG_KNOT_MODE:   knot_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  fsm_state_e state_q, state_d;
  logic [Q16_W-1:0] u_q, u_d, acc_q, acc_d, q0_q, q0_d, ui_q, ui_d, alpha_q, alpha_d;
  logic [DW-1:0]    kr_q, kr_d, r0_q, r0_d, dd_q, dd_d;
  logic [KIW-1:0]   gi_q, gi_d, s_q, s_d, k_q, k_d, top_q, top_d, fst_q, fst_d;
  logic [KIW-1:0]   pidx_q, pidx_d;
  logic             found_q, found_d, emit_row_q, emit_row_d;
  logic [Q16_W-1:0] win_q [WIN];
  logic [Q16_W-1:0] win_d [WIN];
  logic [JW-1:0]    h_q, h_d, r_q, r_d, j_q, j_d;
  logic [DIMW-1:0]  c_q, c_d;
  logic signed [CW-1:0] left_q, left_d;
  logic signed [HW-1:0] dh_q, dh_d;
  logic signed [PW-1:0] pl_q, pl_d, ph_q, ph_d;
  status_e          eval_st_q, eval_st_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [1:0]       onum_q, onum_d;
  logic signed [CW-1:0] oval_q, oval_d;
  status_e          ost_q, ost_d;
  logic [KIW-1:0]   ok_q, ok_d, os_q, os_d;
  logic             olast_q, olast_d;
  logic             out_free;

  // shared divider
  logic                 div_start;
  logic [DIV_N_W-1:0]   div_dividend;
  logic [Q16_W-1:0]     div_divisor;
  logic [DIV_N_W-1:0]   div_quo_q;
  logic [Q16_W-1:0]     div_rem_q, div_den_q;
  logic [DCW-1:0]       div_cnt_q;
  logic [Q16_W:0]       div_shift;
  logic                 div_ge;

  // memories
  logic                 st_we, st_re, row_we, row_re;
  logic [SAW-1:0]       st_waddr, st_raddr;
  logic [RAW-1:0]       row_waddr, row_raddr;
  logic signed [CW-1:0] st_rdata, row_rdata, row_wdata;

  // shared combinational values
  logic [3:0]       ord;
  logic             bad_cfg, in_acc, wr_ok, c_last;
  logic [DW-1:0]    d_val;
  logic [KIW-1:0]   nk_m1, kk, i_a, i_b, widx_full;
  logic [Q16_W-1:0] kv, win_rd;
  logic             adv, hit, above, fnd, srch_done;
  logic [DW:0]      kr_sum;
  logic             kr_wrap;
  logic signed [SW-1:0] k_s, s_s, pc_s, fstd_s, lst_s;
  logic signed [CW:0]   diff;
  logic signed [17:0]   mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic [PW-17:0]       rnd;
  logic signed [VW-1:0] blend_v;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign ord        = {1'b0, degree_q} + 4'd1;
  assign c_last     = (c_q == DIMW'(dimension_q - 3'd1));

  // configuration check and knot step divisor
  always_comb begin
    bad_cfg = (point_count_q == 7'd0) || (32'(point_count_q) > MAX_POINTS) ||
              (7'(degree_q) >= point_count_q) || (32'(degree_q) > MAX_DEGREE) ||
              (dimension_q == 3'd0) || (32'(dimension_q) > MAX_DIM);
    d_val   = knot_mode_q ? DW'({1'b0, point_count_q} - 8'(degree_q))
                          : DW'({1'b0, point_count_q} + 8'(degree_q));
    nk_m1   = KIW'({1'b0, point_count_q} + 8'(degree_q));
    wr_ok   = (32'(point_index_i) < MAX_POINTS) && (32'(coord_select_i) < MAX_DIM);
  end

  // knot generator: one knot a cycle, remainder kept below the divisor
  always_comb begin
    if (!knot_mode_q) begin
      kv = acc_q;
    end else if (gi_q < KIW'(ord)) begin
      kv = '0;
    end else if (gi_q >= KIW'(point_count_q)) begin
      kv = ONE_Q16;
    end else begin
      kv = acc_q;
    end
    adv     = !knot_mode_q || ((gi_q + KIW'(1)) >= KIW'(ord));
    kr_sum  = {1'b0, kr_q} + {1'b0, r0_q};
    kr_wrap = kr_sum >= {1'b0, dd_q};
    hit     = (kv == u_q);
    above   = (u_q < kv);
    fnd     = found_q || (!hit && above);
    kk      = found_q ? k_q : (gi_q - KIW'(1));
    srch_done = fnd ? ({1'b0, gi_q} >= ({1'b0, kk} + (KIW + 1)'(degree_q)))
                    : (gi_q == nk_m1);
  end

  // span checks
  always_comb begin
    k_s    = $signed(SW'(k_q));
    s_s    = $signed(SW'(s_q));
    pc_s   = $signed(SW'(point_count_q));
    fstd_s = k_s - $signed(SW'(degree_q));
    lst_s  = k_s - s_s;
  end

  // knot window read, one address a cycle
  always_comb begin
    i_a = fst_q + KIW'(r_q) + KIW'(j_q);
    i_b = i_a + KIW'(degree_q) - KIW'(r_q) + KIW'(1);
    widx_full = (state_q == S_KNOT_I) ? (top_q - i_a) : (top_q - i_b);
    win_rd = win_q[widx_full[WXW-1:0]];
  end

  // blend arithmetic around the shared multiplier
  always_comb begin
    diff    = $signed({row_rdata[CW-1], row_rdata}) - $signed({left_q[CW-1], left_q});
    mul_a   = $signed({1'b0, alpha_q});
    mul_b   = (state_q == S_MUL_LO) ? $signed(BW'({1'b0, diff[15:0]})) : BW'(dh_q);
    mul_p   = PW'(mul_a) * PW'(mul_b);
    rnd     = (PW - 16)'((pl_q + $signed(HALF_LSB)) >>> 16);
    blend_v = VW'(left_q) + VW'(ph_q) + $signed(VW'(rnd));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (cmd_e'(cmd_i) == CMD_EVAL)) begin
          state_d = bad_cfg ? S_ERR : S_SETUP;
        end
      end
      S_SETUP:      state_d = S_SETUP_WAIT;
      S_SETUP_WAIT: if (div_cnt_q == '0) state_d = S_SEARCH;
      S_SEARCH:     if (srch_done) state_d = S_CHECK;
      S_CHECK: begin
        if (s_q > KIW'(ord)) begin
          state_d = S_ERR;
        end else if (s_q == KIW'(ord)) begin
          state_d = S_EMIT_RD;
        end else if ((fstd_s < 0) || (lst_s >= pc_s)) begin
          state_d = S_ERR;
        end else begin
          state_d = S_LOAD_RD;
        end
      end
      S_LOAD_RD: state_d = S_LOAD_WR;
      S_LOAD_WR: begin
        if (!c_last || (j_q != h_q)) begin
          state_d = S_LOAD_RD;
        end else begin
          state_d = (h_q == '0) ? S_EMIT_RD : S_KNOT_I;
        end
      end
      S_KNOT_I: state_d = S_KNOT_J;
      S_KNOT_J: begin
        if ((win_rd == ui_q) || (u_q <= ui_q)) begin
          state_d = S_ROW_RDL;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:     if (div_cnt_q == '0) state_d = S_ROW_RDL;
      S_ROW_RDL: state_d = S_ROW_RDR;
      S_ROW_RDR: state_d = S_MUL_LO;
      S_MUL_LO:  state_d = S_MUL_HI;
      S_MUL_HI:  state_d = S_ROW_WR;
      S_ROW_WR: begin
        if (!c_last) begin
          state_d = S_ROW_RDL;
        end else if ((j_q == h_q - r_q) && (r_q == h_q)) begin
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_KNOT_I;
        end
      end
      S_EMIT_RD: state_d = S_EMIT_LD;
      S_EMIT_LD: begin
        if (out_free) begin
          state_d = c_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_ERR:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, memory and output control
  always_comb begin
    u_d = u_q;  acc_d = acc_q;  q0_d = q0_q;  ui_d = ui_q;  alpha_d = alpha_q;
    kr_d = kr_q;  r0_d = r0_q;  dd_d = dd_q;
    gi_d = gi_q;  s_d = s_q;  k_d = k_q;  top_d = top_q;  fst_d = fst_q;  pidx_d = pidx_q;
    found_d = found_q;  emit_row_d = emit_row_q;
    h_d = h_q;  r_d = r_q;  j_d = j_q;  c_d = c_q;
    left_d = left_q;  dh_d = dh_q;  pl_d = pl_q;  ph_d = ph_q;  eval_st_d = eval_st_q;
    win_d = win_q;
    out_valid_d = out_valid_q && !out_ready_i;
    onum_d = onum_q;  oval_d = oval_q;  ost_d = ost_q;  ok_d = ok_q;  os_d = os_q;
    olast_d = olast_q;
    div_start = 1'b0;  div_dividend = '0;  div_divisor = '0;
    st_we = 1'b0;  st_re = 1'b0;  row_we = 1'b0;  row_re = 1'b0;
    st_waddr = {PIW'(point_index_i), DIMW'(coord_select_i)};
    st_raddr = {pidx_q[PIW-1:0], c_q};
    row_waddr = {j_q[RJW-1:0], c_q};
    row_raddr = {j_q[RJW-1:0], c_q};
    row_wdata = st_rdata;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(cmd_i) == CMD_WRITE) begin
            st_we = wr_ok;
          end else begin
            u_d       = param_u_i;
            eval_st_d = STAT_UNDEF;
            k_d       = '0;
            s_d       = '0;
          end
        end
      end
      S_SETUP: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(ONE_Q16);
        div_divisor  = Q16_W'(d_val);
      end
      S_SETUP_WAIT: begin
        if (div_cnt_q == '0) begin
          q0_d    = div_quo_q[Q16_W-1:0];
          r0_d    = div_rem_q[DW-1:0];
          dd_d    = d_val;
          acc_d   = '0;
          kr_d    = d_val >> 1;
          gi_d    = '0;
          s_d     = '0;
          found_d = 1'b0;
        end
      end
      S_SEARCH: begin
        win_d[0] = kv;
        for (int w = 1; w < WIN; w++) begin
          win_d[w] = win_q[w-1];
        end
        top_d = gi_q;
        gi_d  = gi_q + KIW'(1);
        if (adv) begin
          acc_d = acc_q + q0_q + Q16_W'(kr_wrap);
          kr_d  = kr_wrap ? DW'(kr_sum - {1'b0, dd_q}) : DW'(kr_sum);
        end
        if (!found_q) begin
          if (hit) begin
            s_d = s_q + KIW'(1);
          end else if (above) begin
            found_d = 1'b1;
            k_d     = gi_q - KIW'(1);
          end
        end
        if (srch_done && !fnd) begin
          k_d = gi_q;
        end
      end
      S_CHECK: begin
        c_d = '0;
        j_d = '0;
        if (s_q > KIW'(ord)) begin
          eval_st_d = STAT_MULT_HIGH;
        end else if (s_q == KIW'(ord)) begin
          emit_row_d = 1'b0;
          if (lst_s < 0) begin
            pidx_d    = '0;
            eval_st_d = STAT_COPY_ONE;
          end else if (lst_s + SW'(1) >= pc_s) begin
            pidx_d    = KIW'(lst_s);
            eval_st_d = STAT_COPY_ONE;
          end else begin
            pidx_d    = KIW'(lst_s + SW'(1));
            eval_st_d = STAT_COPY_TWO;
          end
        end else begin
          eval_st_d = STAT_UNDEF;
          fst_d     = KIW'(fstd_s);
          pidx_d    = KIW'(fstd_s);
          h_d       = JW'(KIW'(degree_q) - s_q);
          emit_row_d = 1'b1;
        end
      end
      S_LOAD_RD: begin
        st_re = 1'b1;
      end
      S_LOAD_WR: begin
        row_we    = 1'b1;
        row_wdata = st_rdata;
        eval_st_d = STAT_DEBOOR;
        if (!c_last) begin
          c_d = c_q + DIMW'(1);
        end else begin
          c_d    = '0;
          pidx_d = pidx_q + KIW'(1);
          j_d    = (j_q == h_q) ? '0 : (j_q + JW'(1));
          r_d    = JW'(1);
        end
      end
      S_KNOT_I: begin
        ui_d = win_rd;
        c_d  = '0;
      end
      S_KNOT_J: begin
        alpha_d = '0;
        if ((win_rd != ui_q) && (u_q > ui_q)) begin
          div_start    = 1'b1;
          div_dividend = {u_q - ui_q, 16'd0};
          div_divisor  = win_rd - ui_q;
        end
      end
      S_DIV: begin
        if (div_cnt_q == '0) begin
          alpha_d = (div_quo_q > DIV_N_W'(ONE_Q16)) ? ONE_Q16 : div_quo_q[Q16_W-1:0];
        end
      end
      S_ROW_RDL: begin
        row_re = 1'b1;
      end
      S_ROW_RDR: begin
        left_d    = row_rdata;
        row_re    = 1'b1;
        row_raddr = {RJW'(j_q + JW'(1)), c_q};
      end
      S_MUL_LO: begin
        dh_d = diff[CW:16];
        pl_d = mul_p;
      end
      S_MUL_HI: begin
        ph_d = mul_p;
      end
      S_ROW_WR: begin
        row_we    = 1'b1;
        row_wdata = CW'(blend_v);
        if (!c_last) begin
          c_d = c_q + DIMW'(1);
        end else begin
          c_d = '0;
          if (j_q == h_q - r_q) begin
            j_d = '0;
            r_d = r_q + JW'(1);
          end else begin
            j_d = j_q + JW'(1);
          end
        end
      end
      S_EMIT_RD: begin
        st_re     = !emit_row_q;
        row_re    = emit_row_q;
        row_raddr = {RJW'(0), c_q};
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          onum_d      = 2'(c_q);
          oval_d      = emit_row_q ? row_rdata : st_rdata;
          ost_d       = eval_st_q;
          ok_d        = k_q;
          os_d        = s_q;
          olast_d     = c_last;
          c_d         = c_q + DIMW'(1);
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          onum_d      = '0;
          oval_d      = '0;
          ost_d       = eval_st_q;
          ok_d        = k_q;
          os_d        = s_q;
          olast_d     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (div_start) begin
        div_cnt_q <= DCW'(DIV_N_W);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  assign div_shift = {div_rem_q, div_quo_q[DIV_N_W-1]};
  assign div_ge    = div_shift >= {1'b0, div_den_q};

  // payload registers
  always_ff @(posedge clk_i) begin
    u_q <= u_d;  acc_q <= acc_d;  q0_q <= q0_d;  ui_q <= ui_d;  alpha_q <= alpha_d;
    kr_q <= kr_d;  r0_q <= r0_d;  dd_q <= dd_d;
    gi_q <= gi_d;  s_q <= s_d;  k_q <= k_d;  top_q <= top_d;  fst_q <= fst_d;
    pidx_q <= pidx_d;  found_q <= found_d;  emit_row_q <= emit_row_d;
    h_q <= h_d;  r_q <= r_d;  j_q <= j_d;  c_q <= c_d;
    left_q <= left_d;  dh_q <= dh_d;  pl_q <= pl_d;  ph_q <= ph_d;  eval_st_q <= eval_st_d;
    win_q <= win_d;
    onum_q <= onum_d;  oval_q <= oval_d;  ost_q <= ost_d;  ok_q <= ok_d;  os_q <= os_d;
    olast_q <= olast_d;
    if (div_start) begin
      div_quo_q <= div_dividend;
      div_rem_q <= '0;
      div_den_q <= div_divisor;
    end else if (div_cnt_q != '0) begin
      div_quo_q <= {div_quo_q[DIV_N_W-2:0], div_ge};
      div_rem_q <= div_ge ? Q16_W'(div_shift - {1'b0, div_den_q}) : Q16_W'(div_shift);
    end
  end

  // control point store
  bsde_ram #(
    .WIDTH (CW),
    .DEPTH (STORE_DEPTH)
  ) u_point_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (coord_in_i),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // working row of the triangle
  bsde_ram #(
    .WIDTH (CW),
    .DEPTH (ROW_DEPTH)
  ) u_net_row (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign coord_number_o = onum_q;
  assign coord_out_o    = oval_q;
  assign status_o       = ost_q;
  assign knot_span_o    = CNT_W'(ok_q);
  assign multiplicity_o = CNT_W'(os_q);
  assign last_o         = olast_q;

`ifndef SYNTH
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW_RDL) |-> (alpha_q <= ONE_Q16))
    else $error("alpha above one");

  a_window_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KNOT_I || state_q == S_KNOT_J) |-> (widx_full < KIW'(WIN)))
    else $error("knot outside the window");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (div_cnt_q == '0))
    else $error("divider restarted while busy");
`endif

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsde_pkg::*;

  localparam longint ONE = 65536;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    cmd_e        cmd;
    logic [5:0]  pidx;
    logic [1:0]  csel;
    logic [31:0] cval;
    logic [16:0] u;
  } req_t;

  typedef struct {
    logic [1:0]  cn;
    logic [31:0] co;
    status_e     st;
    logic [6:0]  span;
    logic [6:0]  mult;
    logic        last;
  } coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [5:0] point_index_i = '0;
  logic [1:0] coord_select_i = '0;
  logic signed [31:0] coord_in_i = '0;
  logic [16:0] param_u_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] coord_number_o;
  logic signed [31:0] coord_out_o;
  logic [2:0] status_o;
  logic [6:0] knot_span_o, multiplicity_o;
  logic last_o;

  bspline_de_boor_evaluator u_top (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  longint m_deg = 3, m_dim = 2, m_pc = 4, m_mode = 1;
  longint pts [0:255];
  req_t   item_q[$];
  coord_t coord_q[$];
  int     errors = 0, items_done = 0, evals_done = 0, results_seen = 0, phases = 0;
  int     snd_idle = 0, rcv_stall = 0;
  logic   in_acc = 1'b0;
  longint cycles = 0;

  function automatic bit cfg_ok();
    return !(m_pc < 1 || m_pc > 64 || m_deg >= m_pc || m_deg > 7 || m_dim < 1 || m_dim > 4);
  endfunction

  function automatic longint knot_at(longint i, longint nk);
    longint ord, d, j;
    ord = m_deg + 1;
    if (m_mode == 0) begin
      d = nk - 1;
      if (d <= 0) return 0;
      return (i * ONE + d / 2) / d;
    end
    if (i < ord) return 0;
    if (i >= nk - ord) return ONE;
    j = i - ord + 1;
    d = m_pc - m_deg;
    return (j * ONE + d / 2) / d;
  endfunction

  function automatic longint mix(longint l, longint r, longint a);
    longint d, dh, dl;
    d = r - l;
    dh = (d >= 0) ? d / ONE : -((-d + ONE - 1) / ONE);
    dl = d - dh * ONE;
    return l + a * dh + (a * dl + ONE / 2) / ONE;
  endfunction

  function automatic void push_res(longint cn, longint v, status_e st, longint k, longint s,
                                   bit lst);
    coord_t e;
    e.cn = cn[1:0];
    e.co = v[31:0];
    e.st = st;
    e.span = k[6:0];
    e.mult = s[6:0];
    e.last = lst;
    coord_q.push_back(e);
  endfunction

  // expected point for an evaluate item
  function automatic void eval_point(longint u);
    longint nk, ord, k, s, kn, fst, lst, h, src, ui, den, a, i;
    longint row [0:31];
    status_e st;
    if (!cfg_ok()) begin
      push_res(0, 0, STAT_UNDEF, 0, 0, 1);
      return;
    end
    ord = m_deg + 1;
    nk = m_pc + ord;
    s = 0;
    for (k = 0; k < nk; k++) begin
      kn = knot_at(k, nk);
      if (kn == u) s++;
      else if (u < kn) break;
    end
    k--;
    if (s > ord) begin
      push_res(0, 0, STAT_MULT_HIGH, k, s, 1);
      return;
    end
    if (s == ord) begin
      fst = k - s;
      st = STAT_COPY_ONE;
      if (fst < 0) src = 0;
      else if (fst + 1 >= m_pc) src = fst;
      else begin
        src = fst + 1;
        st = STAT_COPY_TWO;
      end
      for (int c = 0; c < m_dim; c++)
        push_res(c, pts[src * 4 + c], st, k, s, c == m_dim - 1);
      return;
    end
    fst = k - m_deg;
    lst = k - s;
    h = m_deg - s;
    if (fst < 0 || lst >= m_pc) begin
      push_res(0, 0, STAT_UNDEF, k, s, 1);
      return;
    end
    for (int j = 0; j <= h; j++)
      for (int c = 0; c < m_dim; c++) row[j * 4 + c] = pts[(fst + j) * 4 + c];
    for (int r = 1; r <= h; r++)
      for (int j = 0; j <= h - r; j++) begin
        i = fst + r + j;
        ui = knot_at(i, nk);
        den = knot_at(i + m_deg - r + 1, nk) - ui;
        a = 0;
        if (den != 0) begin
          a = ((u - ui) * ONE) / den;
          if (a < 0) a = 0;
          if (a > ONE) a = ONE;
        end
        for (int c = 0; c < m_dim; c++)
          row[j * 4 + c] = mix(row[j * 4 + c], row[(j + 1) * 4 + c], a);
      end
    for (int c = 0; c < m_dim; c++)
      push_res(c, row[c], STAT_DEBOOR, k, s, c == m_dim - 1);
  endfunction

  // item acceptance, config tracking, result checking, timeout
  always @(posedge clk_i) begin
    coord_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      in_acc <= in_valid_i && in_ready_o;
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_DEGREE:      m_deg = cfg_data_i & 7;
          CFG_DIMENSION:   m_dim = cfg_data_i & 7;
          CFG_POINT_COUNT: m_pc = cfg_data_i & 127;
          CFG_KNOT_MODE:   m_mode = cfg_data_i & 1;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        items_done++;
        if (cmd_i == CMD_WRITE) pts[point_index_i * 4 + coord_select_i] = coord_in_i;
        else begin
          evals_done++;
          eval_point(param_u_i);
        end
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (coord_q.size() == 0) begin
          $error("result with nothing expected: coord_out %h", coord_out_o);
          errors++;
        end else begin
          e = coord_q.pop_front();
          if (coord_number_o !== e.cn) begin
            $error("coord_number exp %0d got %0d", e.cn, coord_number_o); errors++;
          end
          if (coord_out_o !== e.co) begin
            $error("coord_out exp %h got %h", e.co, coord_out_o); errors++;
          end
          if (status_o !== e.st) begin
            $error("status exp %0d got %0d", e.st, status_o); errors++;
          end
          if (knot_span_o !== e.span) begin
            $error("knot_span exp %0d got %0d", e.span, knot_span_o); errors++;
          end
          if (multiplicity_o !== e.mult) begin
            $error("multiplicity exp %0d got %0d", e.mult, multiplicity_o); errors++;
          end
          if (last_o !== e.last) begin
            $error("last exp %0d got %0d", e.last, last_o); errors++;
          end
        end
      end
    end
  end

  // driver: present pending items, random receiver stalls
  always @(negedge clk_i) begin
    req_t it;
    if (rst_ni) begin
      if (!in_valid_i || in_acc) begin
        if (item_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
          it = item_q.pop_front();
          cmd_i <= it.cmd;
          point_index_i <= it.pidx;
          coord_select_i <= it.csel;
          coord_in_i <= it.cval;
          param_u_i <= it.u;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // stimulus generation
  bit written [0:255];

  task automatic add_write(int p, int c, logic [31:0] v);
    req_t it;
    it.cmd = CMD_WRITE;
    it.pidx = 6'(p);
    it.csel = 2'(c);
    it.cval = v;
    it.u = 17'($urandom);
    item_q.push_back(it);
    written[p * 4 + c] = 1;
  endtask

  task automatic add_eval(logic [16:0] u);
    req_t it;
    it.cmd = CMD_EVAL;
    it.pidx = 6'($urandom);
    it.csel = 2'($urandom);
    it.cval = $urandom;
    it.u = u;
    item_q.push_back(it);
  endtask

  task automatic wait_idle();
    wait (item_q.size() == 0 && !in_valid_i && coord_q.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_cfg(int deg, int dim, int pc, int km);
    int v [4];
    v = '{deg, dim, pc, km};
    for (int r = 0; r < 4; r++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= cfg_index_e'(r);
      cfg_data_i <= CFG_W'(v[r]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int deg, int dim, int pc, int km, int n);
    int lim, r, mode;
    longint nk;
    wait_idle();
    set_cfg(deg, dim, pc, km);
    mode = phases % 4;
    snd_idle = (mode == 1) ? 76 : (mode == 3) ? 37 : 0;
    rcv_stall = (mode == 2) ? 76 : (mode == 3) ? 37 : 0;
    phases++;
    lim = (pc > 64) ? 64 : pc;
    // every point the curve may touch gets written first
    for (int p = 0; p < lim; p++)
      for (int c = 0; c < 4; c++)
        if (!written[p * 4 + c]) add_write(p, c, $urandom);
    @(posedge clk_i);
    nk = m_pc + m_deg + 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 15) add_write($urandom_range(lim - 1), $urandom_range(3), $urandom);
      else if (r < 20) add_write($urandom_range(63), $urandom_range(3), $urandom);
      else if (r < 55 && cfg_ok()) add_eval(17'(knot_at($urandom_range(nk - 1), nk)));
      else if (r < 62) add_eval($urandom_range(1) ? 17'd0 : ONE_Q16);
      else if (r < 70) add_eval(17'($urandom_range(131071, 65537)));
      else add_eval(17'($urandom_range(65536)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extreme coordinates and parameters at reset settings
    add_write(0, 0, 32'h7fffffff);
    add_write(0, 1, 32'h80000000);
    add_write(1, 0, 32'h80000000);
    add_write(1, 1, 32'h7fffffff);
    add_write(2, 0, 32'h0);
    add_write(2, 1, 32'hffffffff);
    add_write(3, 0, 32'h00010000);
    add_write(3, 1, 32'hfffe0000);
    for (int p = 0; p < 4; p++)
      for (int c = 2; c < 4; c++) add_write(p, c, $urandom);
    add_write(63, 3, 32'h12345678);
    add_eval(17'd0);
    add_eval(ONE_Q16);
    add_eval(17'd32768);
    add_eval(17'd1);
    add_eval(17'd65535);
    add_eval(17'd65537);
    add_eval(17'h1ffff);
    // settings sweep: extremes, both knot modes and bad configurations
    run_phase(3, 2, 4, 1, 15);
    run_phase(0, 1, 1, 1, 12);
    run_phase(0, 1, 1, 0, 10);
    run_phase(7, 4, 64, 0, 12);
    run_phase(7, 4, 8, 1, 15);
    run_phase(1, 3, 2, 0, 15);
    run_phase(2, 1, 10, 0, 15);
    run_phase(5, 4, 6, 1, 15);
    run_phase(6, 2, 64, 1, 12);
    run_phase(3, 4, 20, 0, 15);
    run_phase(4, 2, 4, 1, 5);
    run_phase(3, 0, 4, 1, 5);
    run_phase(3, 5, 4, 0, 5);
    run_phase(3, 2, 0, 1, 5);
    run_phase(3, 2, 100, 1, 5);
    run_phase(2, 3, 5, 1, 15);
    run_phase(1, 2, 3, 1, 15);
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (coord_q.size() != 0) begin
      $error("%0d expected results never arrived", coord_q.size());
      errors++;
    end
    $display("covered %0d items (%0d evaluations), %0d results over %0d settings",
             items_done, evals_done, results_seen, phases + 1);
    $display("mismatches: %0d, cycles: %0d", errors, cycles);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
